// ===== rtl/brd_pkg.sv =====
`default_nettype none

package brd_pkg;

    localparam int CAP_W = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } brd_action_t;

    typedef struct packed {
        logic res;
        logic err;
    } brd_res_t;

endpackage

`default_nettype wire

// ===== rtl/brd_ram.sv =====
`default_nettype none

module brd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brd_ctrl.sv =====
`default_nettype none

module brd_ctrl #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [brd_pkg::CAP_W-1:0] cfg_wdata,
    input  wire logic                   fire,
    input  wire logic [1:0]             action,
    output logic                        ram_we,
    output logic                        ram_re,
    output logic      [AW-1:0]          ram_addr,
    output brd_pkg::brd_res_t           res
);

    import brd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam int SW = CW + 1;

    logic [CAP_W-1:0] cap_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [EW-1:0]    cap_x;
    logic [CW-1:0]    cap_eff;
    logic [SW-1:0]    sum_back, slot_back;
    logic             full, empty;
    brd_action_t      act;

    assign act   = brd_action_t'(action);
    assign cap_x = EW'(cap_reg);

    always_comb
    begin
        if (cap_x == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_x > EW'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = CW'(cap_x);
        end
    end

    assign full  = occ_reg >= cap_eff;
    assign empty = occ_reg == '0;

    always_comb
    begin
        if (act == ACT_PUSH_BACK)
        begin
            sum_back = SW'(head_reg) + SW'(occ_reg);
        end
        else
        begin
            sum_back = SW'(head_reg) + SW'(occ_reg) - SW'(1);
        end
        slot_back = (sum_back >= SW'(cap_eff)) ? sum_back - SW'(cap_eff) : sum_back;
    end

    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = head_reg;
        res       = '0;
        unique case (act)
            ACT_PUSH_FRONT:
            begin
                if (head_reg == '0)
                begin
                    ram_addr = AW'(cap_eff - CW'(1));
                end
                else
                begin
                    ram_addr = head_reg - AW'(1);
                end
                if (fire && !full)
                begin
                    head_next = ram_addr;
                    occ_next  = occ_reg + CW'(1);
                    ram_we    = 1'b1;
                end
                res.res = full;
                res.err = full;
            end
            ACT_PUSH_BACK:
            begin
                ram_addr = AW'(slot_back);
                if (fire && !full)
                begin
                    occ_next = occ_reg + CW'(1);
                    ram_we   = 1'b1;
                end
                res.res = full;
                res.err = full;
            end
            ACT_POP_FRONT:
            begin
                ram_addr = head_reg;
                if (fire && !empty)
                begin
                    if (CW'(head_reg) + CW'(1) == cap_eff)
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + AW'(1);
                    end
                    occ_next = occ_reg - CW'(1);
                    ram_re   = 1'b1;
                end
                res.res = 1'b1;
                res.err = empty;
            end
            ACT_POP_BACK:
            begin
                ram_addr = AW'(slot_back);
                if (fire && !empty)
                begin
                    occ_next = occ_reg - CW'(1);
                    ram_re   = 1'b1;
                end
                res.res = 1'b1;
                res.err = empty;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg  <= cfg_wdata;
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_eff)
        else $error("occupancy above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(head_reg) < cap_eff)
        else $error("head index outside ring");

    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("read and write in one cycle");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (occ_reg == '0 && head_reg == '0))
        else $error("capacity write did not empty deque");
`endif

endmodule

`default_nettype wire

// ===== rtl/bounded_ring_deque_top.sv =====
`default_nettype none
// Bounded ring deque: push/pop at either end of a ring held in one RAM.
// A result is registered and appears in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle while results are taken; a stalled result
// holds the RAM read register, so input waits until it is taken.
// Reset: head and occupancy clear, capacity returns to 1024; RAM is not cleared.

module bounded_ring_deque_top #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic [1:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // data
    output logic      [0:0]  m_tuser    // is_error
);

    import brd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  fire;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [63:0]           rdata_ext;
    brd_res_t              res;
    logic                  pend_reg, pend_next;
    logic                  err_reg, err_next;

    assign s_tready  = !pend_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign ram_wdata = DATA_WIDTH'(s_tdata);

    brd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .action    (s_tuser),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .res       (res)
    );

    brd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pend_next = pend_reg;
        err_next  = err_reg;
        if (pend_reg && m_tready)
        begin
            pend_next = 1'b0;
        end
        if (fire)
        begin
            pend_next = res.res;
            err_next  = res.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            err_reg  <= err_next;
        end
    end

    assign rdata_ext = 64'(ram_rdata);
    assign m_tvalid  = pend_reg;
    assign m_tuser   = err_reg;
    assign m_tdata   = err_reg ? 32'd0 : rdata_ext[31:0];

`ifndef SYNTH
    a_stall_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !m_tready) |-> !ram_re)
        else $error("RAM read while result stalled");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (pend_reg && !err_reg))
        else $error("pop read lost its result");

    a_error_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.err) |-> (!ram_we && !ram_re))
        else $error("RAM access on error item");
`endif

endmodule

`default_nettype wire
